// ----- hw/rtl/pgs_pkg.sv -----
// ----------------------------------------------------------------------------
// pgs_pkg
// Shared types, constants and helpers of the press gesture page stepper.
// ----------------------------------------------------------------------------
package pgs_pkg;

   localparam int READ_W     = 24;
   localparam int DT_IN_W    = 16;
   localparam int THR_W      = 17;
   localparam int PCNT_W     = 5;
   localparam int PAGE_OUT_W = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;
   localparam int DEV_W      = 20;
   localparam int Q_W        = DEV_W + 1;
   localparam int DT_W       = 7;
   localparam int CNT_W      = 5;

   localparam logic [DT_W-1:0]    DT_LIMIT    = 7'd100;
   localparam logic [THR_W-1:0]   Q16_ONE     = 17'h10000;
   localparam logic [THR_W-1:0]   RELEASE_RST = 17'd300;
   localparam logic [THR_W-1:0]   PRESS_RST   = 17'd1000;
   localparam logic [THR_W-1:0]   GAIN_RST    = 17'd131;
   localparam logic [PCNT_W-1:0]  PCNT_RST    = 5'd2;

   localparam logic [CNT_W-1:0] CMP_LAST   = 5'd25;
   localparam logic [CNT_W-1:0] BASE_STEPS = 5'd24;
   localparam logic [CNT_W-1:0] BASE_LAST  = 5'd23;
   localparam logic [CNT_W-1:0] DEV_STEPS  = 5'd20;
   localparam logic [CNT_W-1:0] MUL_STEPS  = 5'd17;
   localparam logic [CNT_W-1:0] MUL_LAST   = 5'd16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RELEASE,
      CSR_PRESS,
      CSR_GAIN,
      CSR_PAGES
   } csr_index_type;

   typedef enum logic {
      OP_SAMPLE,
      OP_RESTART
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMP,
      ST_DECIDE,
      ST_MUL,
      ST_ADD,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic cmp_en;
      logic cmp_first;
      logic cmp_last;
      logic base_rot;
      logic dev_shift;
      logic mac_clr;
      logic mac_step;
      logic mac_dev;
      logic decide;
      logic q_load;
      logic add_en;
      logic add_first;
      logic out_load;
   } seq_ctl_type;

   typedef struct packed {
      logic dev;
      logic lo;
      logic hi;
      logic up;
      logic dn;
   } cmp_bits_type;

   function automatic logic [1:0] full_add(input logic a, input logic b, input logic c);
      return {(a & b) | (a & c) | (b & c), a ^ b ^ c};
   endfunction

endpackage

// ----- hw/rtl/press_gesture_page_stepper.sv -----
// ----------------------------------------------------------------------------
// press_gesture_page_stepper
// Baseline-tracking press detector that steps a page index up or down.
//
//   channel | ports                                    | handshake
//   --------+------------------------------------------+----------------
//   request | req_op, req_reading, req_elapsed_ms      | req_valid/ready
//   result  | rsp_page, rsp_page_changed, rsp_armed    | rsp_valid/ready
//   config  | csr_index, csr_wdata                     | csr_we
//
// Restart goes straight to the result. Sample outside the release band: 26-bit
// serial compare plus decision. Sample inside the band: adds a 17-step
// shift-add multiply and a 24-bit serial baseline add. Reset is synchronous;
// it restores register defaults, baseline 0, page 0, armed. The result
// register frees the request side; a stalled result holds the sequencer in its
// final step only.
// ----------------------------------------------------------------------------
module press_gesture_page_stepper
   import pgs_pkg::*;
#(
   parameter int MAX_PAGES = 16
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_op,
   input  logic [READ_W-1:0]      req_reading,
   input  logic [DT_IN_W-1:0]     req_elapsed_ms,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [PAGE_OUT_W-1:0]  rsp_page,
   output logic                   rsp_page_changed,
   output logic                   rsp_armed,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int PIDX_W = (MAX_PAGES > 2) ? $clog2(MAX_PAGES) : 1;
   localparam int NCW    = (PIDX_W > PCNT_W) ? PIDX_W + 1 : PCNT_W + 1;

   seq_ctl_type  ctl;
   cmp_bits_type cbits;

   logic [THR_W-1:0]  release_ff, press_ff, gain_ff;
   logic [PCNT_W-1:0] pcount_ff;

   logic [READ_W-1:0] rd_sh_ff, base_ff;
   logic [THR_W-1:0]  rel_sh_ff, prs_sh_ff, gain_sh_ff, prod_lo_ff, factor_ff;
   logic [DT_W-1:0]   dt_ff;
   logic [DEV_W-1:0]  dev_ff;
   logic [Q_W-1:0]    q_ff;
   logic              add_c_ff;
   logic              lo_ff, hi_ff, up_ff, dn_ff;
   logic [PIDX_W-1:0] page_ff;
   logic              armed_ff, changed_ff;
   logic              rsp_valid_ff;
   logic [PAGE_OUT_W-1:0] rsp_page_ff;
   logic              rsp_changed_ff, rsp_armed_ff;

   logic              accept, restart, released, sat;
   logic              mac_mbit, mac_lsb;
   logic [DEV_W-1:0]  mac_addend, mac_acc, mac_acc_nx;
   logic [1:0]        add_r;
   logic [NCW-1:0]    pc_ext, n_eff;
   logic              up_ok, dn_ok;

   assign accept   = req_valid & req_ready;
   assign restart  = (req_op == OP_RESTART);
   assign released = lo_ff & hi_ff;

   pgs_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (restart),
      .released    (released),
      .slot_free   (~rsp_valid_ff | rsp_ready),
      .req_ready   (req_ready),
      .ctl         (ctl)
   );

   pgs_dev_cmp u_cmp (
      .clock   (clock),
      .en      (ctl.cmp_en),
      .first   (ctl.cmp_first),
      .rd_bit  (rd_sh_ff[0]),
      .bl_bit  (ctl.base_rot ? base_ff[0] : base_ff[READ_W-1]),
      .rel_bit (rel_sh_ff[0]),
      .prs_bit (prs_sh_ff[0]),
      .bits    (cbits)
   );

   assign mac_mbit   = ctl.mac_dev ? factor_ff[0] : gain_sh_ff[0];
   assign mac_addend = ctl.mac_dev ? dev_ff : DEV_W'(dt_ff);

   pgs_shift_mac u_mac (
      .clock  (clock),
      .clr    (ctl.mac_clr),
      .step   (ctl.mac_step),
      .mbit   (mac_mbit),
      .addend (mac_addend),
      .acc    (mac_acc),
      .acc_nx (mac_acc_nx),
      .lsb    (mac_lsb)
   );

   always_comb begin
      sat    = (mac_acc != '0) || (prod_lo_ff > Q16_ONE);
      add_r  = full_add(base_ff[0], q_ff[0], ctl.add_first ? 1'b0 : add_c_ff);
      pc_ext = NCW'(pcount_ff);
      if (pc_ext == '0) begin
         n_eff = NCW'(1);
      end else if (pc_ext > NCW'(MAX_PAGES)) begin
         n_eff = NCW'(MAX_PAGES);
      end else begin
         n_eff = pc_ext;
      end
      up_ok = (NCW'(page_ff) + NCW'(1)) < n_eff;
      dn_ok = (page_ff != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         release_ff <= RELEASE_RST;
         press_ff   <= PRESS_RST;
         gain_ff    <= GAIN_RST;
         pcount_ff  <= PCNT_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_RELEASE: release_ff <= csr_wdata[THR_W-1:0];
            CSR_PRESS:   press_ff   <= csr_wdata[THR_W-1:0];
            CSR_GAIN:    gain_ff    <= csr_wdata[THR_W-1:0];
            CSR_PAGES:   pcount_ff  <= csr_wdata[PCNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // serial datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_sh_ff   <= req_reading;
         rel_sh_ff  <= release_ff;
         prs_sh_ff  <= press_ff;
         gain_sh_ff <= gain_ff;
         dt_ff      <= (req_elapsed_ms < DT_IN_W'(DT_LIMIT)) ?
                       req_elapsed_ms[DT_W-1:0] : DT_LIMIT;
      end else if (ctl.cmp_en) begin
         rd_sh_ff  <= {rd_sh_ff[READ_W-1], rd_sh_ff[READ_W-1:1]};
         rel_sh_ff <= {1'b0, rel_sh_ff[THR_W-1:1]};
         prs_sh_ff <= {1'b0, prs_sh_ff[THR_W-1:1]};
         if (ctl.mac_step) begin
            gain_sh_ff <= {1'b0, gain_sh_ff[THR_W-1:1]};
         end
      end
      if (ctl.dev_shift) begin
         dev_ff <= {cbits.dev, dev_ff[DEV_W-1:1]};
      end
      if (ctl.cmp_last) begin
         lo_ff <= cbits.lo;
         hi_ff <= cbits.hi;
         up_ff <= cbits.up;
         dn_ff <= cbits.dn;
      end
      if (ctl.mac_step) begin
         prod_lo_ff <= {mac_lsb, prod_lo_ff[THR_W-1:1]};
      end
      if (ctl.decide) begin
         factor_ff <= sat ? Q16_ONE : prod_lo_ff;
      end else if (ctl.mac_step && ctl.mac_dev) begin
         factor_ff <= {1'b0, factor_ff[THR_W-1:1]};
      end
      if (ctl.q_load) begin
         q_ff <= {mac_acc_nx, mac_lsb};
      end else if (ctl.add_en) begin
         q_ff <= {q_ff[Q_W-1], q_ff[Q_W-1:1]};
      end
      if (ctl.add_en) begin
         add_c_ff <= add_r[1];
      end
   end

   // baseline, page and arm state
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         page_ff  <= '0;
         armed_ff <= 1'b1;
      end else if (accept && restart) begin
         base_ff  <= req_reading;
         page_ff  <= '0;
         armed_ff <= 1'b1;
      end else if (ctl.cmp_en && ctl.base_rot) begin
         base_ff <= {base_ff[0], base_ff[READ_W-1:1]};
      end else if (ctl.add_en) begin
         base_ff <= {add_r[0], base_ff[READ_W-1:1]};
      end else if (ctl.decide) begin
         if (released) begin
            armed_ff <= 1'b1;
         end else if (armed_ff && up_ff && up_ok) begin
            page_ff  <= page_ff + 1'b1;
            armed_ff <= 1'b0;
         end else if (armed_ff && dn_ff && dn_ok) begin
            page_ff  <= page_ff - 1'b1;
            armed_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         changed_ff <= 1'b0;
      end else if (ctl.decide) begin
         changed_ff <= ~released & armed_ff & ((up_ff & up_ok) | (dn_ff & dn_ok));
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         rsp_page_ff    <= PAGE_OUT_W'(page_ff);
         rsp_changed_ff <= changed_ff;
         rsp_armed_ff   <= armed_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_page         = rsp_page_ff;
   assign rsp_page_changed = rsp_changed_ff;
   assign rsp_armed        = rsp_armed_ff;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("request accepted while another is in progress");

   a_step_disarms: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_page_changed |-> !rsp_armed)
      else $error("page step left the detector armed");

   a_page_bound: assert property (@(posedge clock) disable iff (reset)
      int'(page_ff) < MAX_PAGES)
      else $error("page index out of range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.out_load |-> !rsp_valid_ff || rsp_ready)
      else $error("result overwritten before it was taken");

endmodule

// ----- hw/rtl/pgs_dev_cmp.sv -----
// ----------------------------------------------------------------------------
// pgs_dev_cmp
// Bit-serial deviation and threshold compare, LSB first, one bit per cycle.
// ----------------------------------------------------------------------------
module pgs_dev_cmp
   import pgs_pkg::*;
(
   input  logic         clock,
   input  logic         en,
   input  logic         first,
   input  logic         rd_bit,
   input  logic         bl_bit,
   input  logic         rel_bit,
   input  logic         prs_bit,
   output cmp_bits_type bits
);

   // carry order: dev, neg dev, dev-rel, -dev-rel, prs-dev, dev+prs
   localparam logic [5:0] CIN_INIT = 6'b111100;

   logic [5:0] carry_ff;
   logic [5:0] carry_in;
   logic [5:0] cin;
   logic [1:0] d_r, nd_r, lo_r, hi_r, up_r, dn_r;

   always_comb begin
      cin   = first ? CIN_INIT : carry_ff;
      d_r   = full_add(rd_bit, ~bl_bit, cin[5]);
      nd_r  = full_add(bl_bit, ~rd_bit, cin[4]);
      lo_r  = full_add(d_r[0], ~rel_bit, cin[3]);
      hi_r  = full_add(nd_r[0], ~rel_bit, cin[2]);
      up_r  = full_add(prs_bit, nd_r[0], cin[1]);
      dn_r  = full_add(d_r[0], prs_bit, cin[0]);
      carry_in = {d_r[1], nd_r[1], lo_r[1], hi_r[1], up_r[1], dn_r[1]};
      bits.dev = d_r[0];
      bits.lo  = lo_r[0];
      bits.hi  = hi_r[0];
      bits.up  = up_r[0];
      bits.dn  = dn_r[0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         carry_ff <= carry_in;
      end
   end

endmodule

// ----- hw/rtl/pgs_shift_mac.sv -----
// ----------------------------------------------------------------------------
// pgs_shift_mac
// Shift-add multiplier step: one multiplier bit per cycle, product LSB out.
// ----------------------------------------------------------------------------
module pgs_shift_mac
   import pgs_pkg::*;
(
   input  logic             clock,
   input  logic             clr,
   input  logic             step,
   input  logic             mbit,
   input  logic [DEV_W-1:0] addend,
   output logic [DEV_W-1:0] acc,
   output logic [DEV_W-1:0] acc_nx,
   output logic             lsb
);

   logic [DEV_W-1:0] acc_ff;
   logic [DEV_W:0]   sum;

   always_comb begin
      sum    = {acc_ff[DEV_W-1], acc_ff}
             + (mbit ? {addend[DEV_W-1], addend} : {(DEV_W+1){1'b0}});
      acc_nx = sum[DEV_W:1];
      lsb    = sum[0];
      acc    = acc_ff;
   end

   always_ff @(posedge clock) begin
      if (clr) begin
         acc_ff <= '0;
      end else if (step) begin
         acc_ff <= acc_nx;
      end
   end

endmodule

// ----- hw/rtl/pgs_seq.sv -----
// ----------------------------------------------------------------------------
// pgs_seq
// Sequencer: compare pass, decision, serial multiply and baseline add.
// ----------------------------------------------------------------------------
module pgs_seq
   import pgs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_restart,
   input  logic        released,
   input  logic        slot_free,
   output logic        req_ready,
   output seq_ctl_type ctl
);

   seq_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      ctl       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cnt_in    = '0;
            if (req_valid) begin
               ctl.mac_clr = 1'b1;
               state_in    = req_restart ? ST_DONE : ST_CMP;
            end
         end
         ST_CMP: begin
            ctl.cmp_en    = 1'b1;
            ctl.cmp_first = (cnt_ff == '0);
            ctl.base_rot  = (cnt_ff < BASE_STEPS);
            ctl.dev_shift = (cnt_ff < DEV_STEPS);
            ctl.mac_step  = (cnt_ff < MUL_STEPS);
            if (cnt_ff == CMP_LAST) begin
               ctl.cmp_last = 1'b1;
               cnt_in       = '0;
               state_in     = ST_DECIDE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DECIDE: begin
            ctl.decide  = 1'b1;
            ctl.mac_clr = 1'b1;
            state_in    = released ? ST_MUL : ST_DONE;
         end
         ST_MUL: begin
            ctl.mac_step = 1'b1;
            ctl.mac_dev  = 1'b1;
            if (cnt_ff == MUL_LAST) begin
               ctl.q_load = 1'b1;
               cnt_in     = '0;
               state_in   = ST_ADD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_ADD: begin
            ctl.add_en    = 1'b1;
            ctl.add_first = (cnt_ff == '0);
            if (cnt_ff == BASE_LAST) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               ctl.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

endmodule
